// File: rtl/value_noise_4d_cosine_trilinear_unit_assert.svh
// Assertion macros for the checker of the value noise unit.
`ifndef VALUE_NOISE_4D_COSINE_TRILINEAR_UNIT_ASSERT_SVH
`define VALUE_NOISE_4D_COSINE_TRILINEAR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and switched off during reset.
`define VN4C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and switched off during reset.
`define VN4C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vn4c_pkg.sv
// Types, constants and helper functions of the 4-D value noise unit.
package vn4c_pkg;

  localparam int FRAC_BITS_DEF         = 16;
  localparam int WEIGHT_TABLE_BITS_DEF = 10;

  localparam int COORD_W     = 32;
  localparam int SLICE_W     = 16;
  localparam int NOISE_W     = 18;
  localparam int OUT_FRAC    = 16;
  localparam int WEIGHT_W    = OUT_FRAC + 1;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int PIPE_STAGES = 10;

  // The hash result is masked to 31 bits at the end, and every step before that
  // wraps, so only the low 31 bits of each intermediate ever matter.
  localparam int HASH_W     = 31;
  localparam int HASH_SHIFT = 13;
  localparam int NN_SHIFT   = 14;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [HASH_W-1:0]          hash_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic signed [NOISE_W-1:0]  noise_t;
  typedef logic [CFG_ADDR_W-1:0]      cfg_addr_t;

  localparam cfg_addr_t CFG_ADDR_LINEAR_BLEND = 2'd0;

  localparam hash_t HASH_KX = 31'd271;
  localparam hash_t HASH_KY = 31'd1999;
  localparam hash_t HASH_KZ = 31'd3631;
  localparam hash_t HASH_KW = 31'd7919;
  localparam hash_t HASH_M1 = 31'd41333;
  localparam hash_t HASH_A1 = 31'd53307781;
  localparam hash_t HASH_A2 = 31'd1376312589;

  localparam noise_t NOISE_ONE = 18'sd65536;
  localparam logic signed [2*NOISE_W:0] LERP_ROUND = 37'sd32768;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam int TAYLOR_TERMS = 8;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240};

  // (1 - cos(pi*k/2^tbl_bits)) / 2 in Q16 for k up to half the table, cosine by Taylor series.
  function automatic longint unsigned cos_half(input longint unsigned k, input int tbl_bits);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          hc;
    theta = (PI_Q30 * k) >> tbl_bits;
    x2    = (theta * theta) >> 30;
    term  = Q30_ONE;
    sum   = longint'(Q30_ONE);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    hc = longint'(Q30_ONE) - sum;
    if (hc < 0) begin
      hc = 0;
    end
    return unsigned'((hc + 16384) >>> 15);
  endfunction

  // Table entry k; the upper half mirrors the lower half about one half.
  function automatic weight_t cos_weight(input longint unsigned k, input int tbl_bits);
    longint unsigned full;
    longint unsigned val;
    full = 64'd1 << tbl_bits;
    if (k <= (full >> 1)) begin
      val = cos_half(k, tbl_bits);
    end else begin
      val = 64'd65536 - cos_half(full - k, tbl_bits);
    end
    return val[WEIGHT_W-1:0];
  endfunction

  // floor((a*(1-wt) + b*wt + 0.5)) in Q16, written as a + (b-a)*wt.
  function automatic noise_t lerp(input noise_t a, input noise_t b, input weight_t wt);
    logic signed [NOISE_W:0]   diff;
    logic signed [2*NOISE_W:0] prod;
    logic signed [2*NOISE_W:0] rnd;
    diff = {b[NOISE_W-1], b} - {a[NOISE_W-1], a};
    prod = diff * $signed({1'b0, wt});
    rnd  = (prod + LERP_ROUND) >>> OUT_FRAC;
    return a + rnd[NOISE_W-1:0];
  endfunction

endpackage

// File: rtl/value_noise_4d_cosine_trilinear_unit.sv
// Top level of the 4-D value noise unit: ten-stage pipelined sampler with config port.
//
// Usage. Each input beat carries a 3-D point (in_x_coord, in_y_coord, in_z_coord, signed
// fixed point with FRAC_BITS fraction bits) and an integer slice in_w_slice. Each output
// beat carries out_noise_value, the trilinearly blended lattice noise in signed Q2.16.
// Both channels use valid and ready; a beat moves when both are high.
// out_valid rises once the beat has passed all ten register stages, and the block accepts
// one beat every cycle unless the pipeline is full and the receiver stalls: each of the ten
// register stages holds an item of its own.
// Stage work: split into lattice corner and fraction; base hash and weight table read;
// the eight corner hashes; three stages of 31-bit multiplies per corner; corner values;
// then the x, y and z blends, the last of which feeds the output register.
// When the receiver stalls, ready ripples back stage by stage, so empty stages still
// fill up and in_ready stays high until the pipeline is really full. Nothing is lost or
// repeated and a held output beat keeps its value.
// Reset (rst_n low at a clock edge) empties the pipeline and selects the cosine blend;
// the block takes beats as soon as reset is released, with no clearing pass.
// Register linear_blend (byte address 0, bit 0) picks the plain linear weight when set;
// write it only while no beat is in flight.
module value_noise_4d_cosine_trilinear_unit #(
  parameter int FRAC_BITS         = vn4c_pkg::FRAC_BITS_DEF,
  parameter int WEIGHT_TABLE_BITS = vn4c_pkg::WEIGHT_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vn4c_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [vn4c_pkg::COORD_W-1:0] in_y_coord,
  input  logic signed [vn4c_pkg::COORD_W-1:0] in_z_coord,
  input  logic signed [vn4c_pkg::SLICE_W-1:0] in_w_slice,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vn4c_pkg::NOISE_W-1:0] out_noise_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vn4c_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [vn4c_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [vn4c_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import vn4c_pkg::*;

  localparam int TBL_SIZE = 2 ** WEIGHT_TABLE_BITS;

  // Configuration register.
  logic linear_blend_r;

  // Pipeline control: one valid bit per stage, and a per-stage load enable that lets
  // a stage take new data whenever it is empty or its contents move on.
  logic [PIPE_STAGES:1]   valid_r;
  logic [PIPE_STAGES+1:1] stage_en;

  // Stage 1: lattice corner (low 31 bits are all the hash needs) and fraction magnitude.
  logic signed [COORD_W-1:0] coord     [NUM_AXES];
  logic [COORD_W-1:0]        coord_neg [NUM_AXES];
  hash_t                     ip_nxt    [NUM_AXES];
  logic [FRAC_BITS-1:0]      mag_nxt   [NUM_AXES];
  hash_t                     ip_r      [NUM_AXES];
  logic [FRAC_BITS-1:0]      mag_r     [NUM_AXES];
  logic signed [SLICE_W-1:0] slice_r;

  // Stage 2: base hash of the lower corner; the weight table reads sit in g_axis.
  hash_t h0_nxt;
  hash_t h0_r;

  // Stage 3 onwards: corner hashes, products, corner values and blends.
  weight_t wt_sel     [NUM_AXES];
  weight_t wt_r       [3:PIPE_STAGES-1][NUM_AXES];
  hash_t   corner_h   [NUM_CORNERS];
  hash_t   hm_nxt     [NUM_CORNERS];
  hash_t   hm3_r      [NUM_CORNERS];
  hash_t   hm4_r      [NUM_CORNERS];
  hash_t   hm5_r      [NUM_CORNERS];
  hash_t   sq4_r      [NUM_CORNERS];
  hash_t   t5_r       [NUM_CORNERS];
  hash_t   p6_r       [NUM_CORNERS];
  hash_t   nn_nxt     [NUM_CORNERS];
  noise_t  cv_nxt     [NUM_CORNERS];
  noise_t  cv7_r      [NUM_CORNERS];
  noise_t  lx8_r      [NUM_CORNERS/2];
  noise_t  ly9_r      [NUM_CORNERS/4];
  noise_t  noise_r;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; pready is tied high.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linear_blend_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == CFG_ADDR_LINEAR_BLEND)) begin
      linear_blend_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_LINEAR_BLEND) ? CFG_DATA_W'(linear_blend_r) : '0;

  // ---------------------------------------------------------------------------
  // Handshake. The output register is the last stage; ready ripples back from it.
  // ---------------------------------------------------------------------------
  always_comb begin
    stage_en[PIPE_STAGES+1] = out_ready;
    for (int s = PIPE_STAGES; s >= 1; s--) begin
      stage_en[s] = !valid_r[s] || stage_en[s+1];
    end
  end

  assign in_ready        = stage_en[1];
  assign out_valid       = valid_r[PIPE_STAGES];
  assign out_noise_value = noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[1]) begin
        valid_r[1] <= in_valid;
      end
      for (int s = 2; s <= PIPE_STAGES; s++) begin
        if (stage_en[s]) begin
          valid_r[s] <= valid_r[s-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1. Truncation toward zero: a negative coordinate with a non-zero fraction
  // rounds its integer part up by one, and the fraction magnitude is then the low
  // bits of the negated coordinate.
  // ---------------------------------------------------------------------------
  assign coord[0] = in_x_coord;
  assign coord[1] = in_y_coord;
  assign coord[2] = in_z_coord;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      coord_neg[a] = -coord[a];
      ip_nxt[a]    = HASH_W'(coord[a] >>> FRAC_BITS)
                   + HASH_W'(coord[a][COORD_W-1] && (coord[a][FRAC_BITS-1:0] != '0));
      mag_nxt[a]   = coord[a][COORD_W-1] ? coord_neg[a][FRAC_BITS-1:0]
                                         : coord[a][FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      ip_r    <= ip_nxt;
      mag_r   <= mag_nxt;
      slice_r <= in_w_slice;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2. Base hash of the (x, y, z, w) corner; the other seven corners differ
  // from it only by constant offsets.
  // ---------------------------------------------------------------------------
  assign h0_nxt = ip_r[0] * HASH_KX + ip_r[1] * HASH_KY + ip_r[2] * HASH_KZ
                + HASH_W'(slice_r) * HASH_KW;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      h0_r <= h0_nxt;
    end
  end

  // Weight per axis. The cosine table has a registered read in stage 2, one copy
  // per axis; the linear weight is the fraction rescaled to 16 bits. Stage 3 picks.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    weight_t                        cos_rom [TBL_SIZE];
    logic [WEIGHT_TABLE_BITS-1:0]   rom_idx;
    logic [OUT_FRAC-1:0]            lin_wt;
    weight_t                        rom_wt_r;
    logic [OUT_FRAC-1:0]            lin_wt_r;

    for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
      assign cos_rom[k] = cos_weight(64'(k), WEIGHT_TABLE_BITS);
    end

    if (FRAC_BITS >= WEIGHT_TABLE_BITS) begin : g_idx_shr
      assign rom_idx = mag_r[a][FRAC_BITS-1 -: WEIGHT_TABLE_BITS];
    end else begin : g_idx_shl
      assign rom_idx = {mag_r[a], {(WEIGHT_TABLE_BITS-FRAC_BITS){1'b0}}};
    end

    if (FRAC_BITS >= OUT_FRAC) begin : g_lin_shr
      assign lin_wt = mag_r[a][FRAC_BITS-1 -: OUT_FRAC];
    end else begin : g_lin_shl
      assign lin_wt = {mag_r[a], {(OUT_FRAC-FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge clk) begin
      if (stage_en[2]) begin
        rom_wt_r <= cos_rom[rom_idx];
        lin_wt_r <= lin_wt;
      end
    end

    assign wt_sel[a] = linear_blend_r ? {1'b0, lin_wt_r} : rom_wt_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3. Corner hashes and the shift-xor mix. Corner index bit 0 selects x+1,
  // bit 1 y+1 and bit 2 z+1.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      corner_h[c] = h0_r + (c[0] ? HASH_KX : '0) + (c[1] ? HASH_KY : '0)
                  + (c[2] ? HASH_KZ : '0);
      hm_nxt[c]   = (corner_h[c] << HASH_SHIFT) ^ corner_h[c];
    end
  end

  // Weights travel alongside the corners until the blend that uses them.
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      hm3_r   <= hm_nxt;
      wt_r[3] <= wt_sel;
    end
    for (int s = 4; s <= PIPE_STAGES-1; s++) begin
      if (stage_en[s]) begin
        wt_r[s] <= wt_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 to 6. The polynomial of the hash, one 31-bit multiply per corner and
  // stage: the square, the constant scale with its offset, then the outer product.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        sq4_r[c] <= hm3_r[c] * hm3_r[c];
      end
      hm4_r <= hm3_r;
    end
    if (stage_en[5]) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        t5_r[c] <= sq4_r[c] * HASH_M1 + HASH_A1;
      end
      hm5_r <= hm4_r;
    end
    if (stage_en[6]) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        p6_r[c] <= hm5_r[c] * t5_r[c];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7. Final offset and corner value 1 - nn/2^30 in Q16.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      nn_nxt[c] = p6_r[c] + HASH_A2;
      cv_nxt[c] = NOISE_ONE - $signed({1'b0, nn_nxt[c][HASH_W-1:NN_SHIFT]});
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      cv7_r <= cv_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 8 to 10. Blend in x, then y, then z (the z plane towards the z+1 plane).
  // The z blend is the output register itself.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      for (int j = 0; j < NUM_CORNERS/2; j++) begin
        lx8_r[j] <= lerp(cv7_r[2*j], cv7_r[2*j+1], wt_r[7][0]);
      end
    end
    if (stage_en[9]) begin
      for (int m = 0; m < NUM_CORNERS/4; m++) begin
        ly9_r[m] <= lerp(lx8_r[2*m], lx8_r[2*m+1], wt_r[8][1]);
      end
    end
    if (stage_en[10]) begin
      noise_r <= lerp(ly9_r[0], ly9_r[1], wt_r[9][2]);
    end
  end

endmodule

// File: rtl/vn4c_checker.sv
// Port-level checker of the 4-D value noise unit, bound to its top level.
`include "value_noise_4d_cosine_trilinear_unit_assert.svh"

module vn4c_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [vn4c_pkg::NOISE_W-1:0] out_noise_value,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [vn4c_pkg::CFG_ADDR_W-1:0]     paddr,
  input logic [vn4c_pkg::CFG_DATA_W-1:0]     pwdata,
  input logic [vn4c_pkg::CFG_DATA_W-1:0]     prdata
);
  import vn4c_pkg::*;

  // A ready receiver keeps the whole pipeline moving, so input is never refused.
  `VN4C_ASSERT_NOW(a_ready_when_drained, out_ready, in_ready, "in_ready low while out_ready high")

  // A stalled output beat stays and holds its value.
  `VN4C_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_noise_value), "stalled output beat changed or dropped")

  // Blends of values in [-1, 1] stay in [-1, 1].
  `VN4C_ASSERT_NOW(a_noise_range, out_valid, (out_noise_value <= NOISE_ONE) && (out_noise_value >= -NOISE_ONE), "noise value out of range")

  // A write to linear_blend reads back on the next cycle.
  `VN4C_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && (paddr == CFG_ADDR_LINEAR_BLEND), (paddr != CFG_ADDR_LINEAR_BLEND) || (prdata[0] == $past(pwdata[0])), "linear_blend read-back mismatch")

endmodule

bind value_noise_4d_cosine_trilinear_unit vn4c_checker u_vn4c_checker (.*);
